/* src/ssiu_pkg.sv */
// Shared types and constants for the sorted set intersection/union block.
// No dependencies; used by ssiu_chain and sorted_set_intersect_union.
package ssiu_pkg;

    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT_A = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT_B = 3'd1;
    localparam logic [CMD_W-1:0] CMD_EMIT_AND = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EMIT_OR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

    localparam logic LIST_INTERSECT = 1'b0;
    localparam logic LIST_UNION     = 1'b1;

    // Control for one sorted chain, one operation per cycle.
    typedef struct packed {
        logic insert;
        logic rotate;
        logic clear;
    } chain_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_MERGE = 2'b10
    } state_t;

endpackage

/* src/ssiu_cell.sv */
// One cell of a sorted chain: holds a single set member.
// No package dependencies; instantiated by ssiu_chain.
module ssiu_cell #(
    parameter int VALUE_WIDTH = 24
) (
    input  logic                   clk,
    input  logic                   ins_en,
    input  logic                   rot_en,
    input  logic                   valid,
    input  logic                   is_tail,
    input  logic                   prev_gt,
    input  logic                   prev_valid,
    input  logic [VALUE_WIDTH-1:0] ins_value,
    input  logic [VALUE_WIDTH-1:0] prev_value,
    input  logic [VALUE_WIDTH-1:0] next_value,
    input  logic [VALUE_WIDTH-1:0] head_value,
    output logic [VALUE_WIDTH-1:0] value,
    output logic                   gt,
    output logic                   eq
);

    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic                   take_new;

    assign gt = valid && (value_reg > ins_value);
    assign eq = valid && (value_reg == ins_value);
    assign value = value_reg;

    // The new value lands in the first cell that is greater than it, or in the
    // first empty cell; every cell after that point takes its left neighbor.
    assign take_new = !prev_gt && (gt || (!valid && prev_valid));

    always_comb
    begin
        value_next = value_reg;
        if (ins_en)
        begin
            if (prev_gt)
                value_next = prev_value;
            else if (take_new)
                value_next = ins_value;
        end
        else if (rot_en)
        begin
            value_next = is_tail ? head_value : next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* src/ssiu_chain.sv */
// A row of ssiu_cell instances holding one sorted set, plus its fill count.
// Depends on ssiu_pkg (chain_ctrl_t) and ssiu_cell.
module ssiu_chain #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 24,
    parameter int CNT_W       = $clog2(CAPACITY + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ssiu_pkg::chain_ctrl_t  ctrl,
    input  logic [VALUE_WIDTH-1:0] ins_value,
    output logic [VALUE_WIDTH-1:0] head_value,
    output logic [CNT_W-1:0]       count,
    output logic                   overflow_set
);

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]    cell_gt;
    logic [CAPACITY-1:0]    cell_eq;
    logic                   any_eq;
    logic                   full;
    logic                   ins_do;
    logic [CNT_W-1:0]       tail_idx;

    assign any_eq       = |cell_eq;
    assign full         = (count_reg == CNT_W'(CAPACITY));
    assign ins_do       = ctrl.insert && !any_eq && !full;
    assign overflow_set = ctrl.insert && !any_eq && full;
    assign tail_idx     = count_reg - CNT_W'(1);
    assign head_value   = cell_value[0];
    assign count        = count_reg;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                   p_gt;
        logic                   p_valid;
        logic [VALUE_WIDTH-1:0] p_value;
        logic [VALUE_WIDTH-1:0] n_value;

        if (i == 0)
        begin : g_first
            assign p_gt    = 1'b0;
            assign p_valid = 1'b1;
            assign p_value = ins_value;
        end
        else
        begin : g_rest
            assign p_gt    = cell_gt[i-1];
            assign p_valid = (CNT_W'(i - 1) < count_reg);
            assign p_value = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign n_value = cell_value[i];
        end
        else
        begin : g_mid
            assign n_value = cell_value[i+1];
        end

        ssiu_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ins_en     (ins_do),
            .rot_en     (ctrl.rotate),
            .valid      (CNT_W'(i) < count_reg),
            .is_tail    (CNT_W'(i) == tail_idx),
            .prev_gt    (p_gt),
            .prev_valid (p_valid),
            .ins_value  (ins_value),
            .prev_value (p_value),
            .next_value (n_value),
            .head_value (cell_value[0]),
            .value      (cell_value[i]),
            .gt         (cell_gt[i]),
            .eq         (cell_eq[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
            count_next = '0;
        else if (ins_do)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

/* src/sorted_set_intersect_union.sv */
// Top level of the sorted set intersection/union block.
// Depends on ssiu_pkg, ssiu_chain and ssiu_cell.
//
//  Channel | Handshake           | Payload
//  --------+---------------------+-------------------------------------------
//  input   | in_valid, in_ready  | command, value
//  output  | out_valid, out_ready| value_res, valid_res, last, list_kind, overflow
//
// Insert, clear and unknown commands give no beat.
// An emit command walks both chains, one merge step per cycle at the chain
// heads while the output can take a beat. A value held in both sets is consumed
// from both chains in a single step, so the merge takes one step per distinct
// value across both sets plus one closing step, at most count_a + count_b + 1.
// The input channel is ready only while no emit is running.
// Reset empties both sets and clears the sticky overflow flag. A stalled
// output holds the merge in place; nothing is lost.
//
// Each set is a chain of cells kept in ascending order. An insert compares
// the new value against every cell at once; the cells above the insertion
// point shift one place toward the tail. During an emit each chain rotates
// its valid entries toward the head whenever its head value is consumed, so
// after count rotations the chain is back in its original order and the
// emit leaves both sets unchanged.
//
// The most recent member found is held back one step so that the last flag
// can be attached to it once the merge is known to be over; an emit that
// finds nothing gives a single beat with valid_res low and last high.
module sorted_set_intersect_union #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ssiu_pkg::CMD_W-1:0]   command,
    input  logic [VALUE_WIDTH-1:0]       value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [VALUE_WIDTH-1:0]       value_res,
    output logic                         valid_res,
    output logic                         last,
    output logic                         list_kind,
    output logic                         overflow
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ssiu_pkg::state_t       state_reg;
    ssiu_pkg::state_t       state_next;

    ssiu_pkg::chain_ctrl_t  ctrl_a;
    ssiu_pkg::chain_ctrl_t  ctrl_b;
    logic [VALUE_WIDTH-1:0] head_a;
    logic [VALUE_WIDTH-1:0] head_b;
    logic [CNT_W-1:0]       count_a;
    logic [CNT_W-1:0]       count_b;
    logic                   ovf_set_a;
    logic                   ovf_set_b;

    logic                   overflow_reg;
    logic                   kind_reg;
    logic                   kind_next;
    logic [CNT_W-1:0]       idx_a_reg;
    logic [CNT_W-1:0]       idx_a_next;
    logic [CNT_W-1:0]       idx_b_reg;
    logic [CNT_W-1:0]       idx_b_next;
    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    logic [VALUE_WIDTH-1:0] hold_value_reg;
    logic [VALUE_WIDTH-1:0] hold_value_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [VALUE_WIDTH-1:0] out_value_next;
    logic                   out_member_reg;
    logic                   out_member_next;
    logic                   out_last_reg;
    logic                   out_last_next;
    logic                   out_kind_reg;
    logic                   out_kind_next;
    logic                   out_ovf_reg;
    logic                   out_ovf_next;

    logic                   in_fire;
    logic                   step;
    logic                   a_has;
    logic                   b_has;
    logic                   done;
    logic                   rot_a;
    logic                   rot_b;
    logic                   take;
    logic [VALUE_WIDTH-1:0] cand;
    logic                   push;

    assign in_ready = (state_reg == ssiu_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // A merge step runs only when the output register can take a beat.
    assign step  = (state_reg == ssiu_pkg::ST_MERGE) && (!out_valid_reg || out_ready);
    assign a_has = (idx_a_reg < count_a);
    assign b_has = (idx_b_reg < count_b);
    assign done  = !a_has && !b_has;

    // One merge decision at the chain heads.
    always_comb
    begin
        rot_a = 1'b0;
        rot_b = 1'b0;
        take  = 1'b0;
        cand  = head_a;
        if (a_has && b_has)
        begin
            if (head_a == head_b)
            begin
                rot_a = 1'b1;
                rot_b = 1'b1;
                take  = 1'b1;
            end
            else if (head_a < head_b)
            begin
                rot_a = 1'b1;
                take  = kind_reg;
            end
            else
            begin
                rot_b = 1'b1;
                cand  = head_b;
                take  = kind_reg;
            end
        end
        else if (a_has)
        begin
            rot_a = 1'b1;
            take  = kind_reg;
        end
        else if (b_has)
        begin
            rot_b = 1'b1;
            cand  = head_b;
            take  = kind_reg;
        end
    end

    always_comb
    begin
        ctrl_a.insert = in_fire && (command == ssiu_pkg::CMD_INSERT_A);
        ctrl_a.clear  = in_fire && (command == ssiu_pkg::CMD_CLEAR);
        ctrl_a.rotate = step && !done && rot_a;
        ctrl_b.insert = in_fire && (command == ssiu_pkg::CMD_INSERT_B);
        ctrl_b.clear  = in_fire && (command == ssiu_pkg::CMD_CLEAR);
        ctrl_b.rotate = step && !done && rot_b;
    end

    ssiu_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
    ) u_chain_a (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_a),
        .ins_value    (value),
        .head_value   (head_a),
        .count        (count_a),
        .overflow_set (ovf_set_a)
    );

    ssiu_chain #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH),
        .CNT_W       (CNT_W)
    ) u_chain_b (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl_b),
        .ins_value    (value),
        .head_value   (head_b),
        .count        (count_b),
        .overflow_set (ovf_set_b)
    );

    // Sequencer, merge counters and the one-deep hold of the latest member.
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        idx_a_next      = idx_a_reg;
        idx_b_next      = idx_b_reg;
        hold_valid_next = hold_valid_reg;
        hold_value_next = hold_value_reg;
        push            = 1'b0;
        out_value_next  = out_value_reg;
        out_member_next = out_member_reg;
        out_last_next   = out_last_reg;
        out_kind_next   = out_kind_reg;
        out_ovf_next    = out_ovf_reg;

        case (state_reg)
            ssiu_pkg::ST_IDLE:
            begin
                if (in_fire && (command inside {ssiu_pkg::CMD_EMIT_AND,
                                                ssiu_pkg::CMD_EMIT_OR}))
                begin
                    state_next      = ssiu_pkg::ST_MERGE;
                    kind_next       = (command == ssiu_pkg::CMD_EMIT_OR) ?
                                      ssiu_pkg::LIST_UNION : ssiu_pkg::LIST_INTERSECT;
                    idx_a_next      = '0;
                    idx_b_next      = '0;
                    hold_valid_next = 1'b0;
                end
            end
            ssiu_pkg::ST_MERGE:
            begin
                if (step)
                begin
                    if (done)
                    begin
                        push            = 1'b1;
                        out_value_next  = hold_valid_reg ? hold_value_reg : '0;
                        out_member_next = hold_valid_reg;
                        out_last_next   = 1'b1;
                        out_kind_next   = kind_reg;
                        out_ovf_next    = overflow_reg;
                        state_next      = ssiu_pkg::ST_IDLE;
                    end
                    else
                    begin
                        if (rot_a)
                            idx_a_next = idx_a_reg + CNT_W'(1);
                        if (rot_b)
                            idx_b_next = idx_b_reg + CNT_W'(1);
                        if (take)
                        begin
                            // A newer member exists, so the held one is not last.
                            push            = hold_valid_reg;
                            out_value_next  = hold_valid_reg ? hold_value_reg : out_value_reg;
                            out_member_next = hold_valid_reg ? 1'b1 : out_member_reg;
                            out_last_next   = hold_valid_reg ? 1'b0 : out_last_reg;
                            out_kind_next   = hold_valid_reg ? kind_reg : out_kind_reg;
                            out_ovf_next    = hold_valid_reg ? overflow_reg : out_ovf_reg;
                            hold_valid_next = 1'b1;
                            hold_value_next = cand;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ssiu_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = push ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ssiu_pkg::ST_IDLE;
            overflow_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            kind_reg       <= 1'b0;
            idx_a_reg      <= '0;
            idx_b_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            overflow_reg   <= overflow_reg || ovf_set_a || ovf_set_b;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            kind_reg       <= kind_next;
            idx_a_reg      <= idx_a_next;
            idx_b_reg      <= idx_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_value_reg <= hold_value_next;
        out_value_reg  <= out_value_next;
        out_member_reg <= out_member_next;
        out_last_reg   <= out_last_next;
        out_kind_reg   <= out_kind_next;
        out_ovf_reg    <= out_ovf_next;
    end

    assign out_valid = out_valid_reg;
    assign value_res = out_value_reg;
    assign valid_res = out_member_reg;
    assign last      = out_last_reg;
    assign list_kind = out_kind_reg;
    assign overflow  = out_ovf_reg;

endmodule

/* dv/tb_sorted_set_intersect_union.sv */
// Self-checking testbench for sorted_set_intersect_union: directed and random command
// streams with a scoreboard that predicts every output beat of each emit command.
// Depends on ssiu_pkg and the sorted_set_intersect_union RTL.
`timescale 1ns / 1ps

module tb_sorted_set_intersect_union;

    localparam int CAP = 32;
    localparam int VW  = 24;

    // Command codes above CMD_CLEAR are unused; the block must ignore them.
    localparam logic [ssiu_pkg::CMD_W-1:0] CMD_RSVD_0 = 3'd5;
    localparam logic [ssiu_pkg::CMD_W-1:0] CMD_RSVD_1 = 3'd6;
    localparam logic [ssiu_pkg::CMD_W-1:0] CMD_RSVD_2 = 3'd7;

    localparam logic [VW-1:0] VAL_MAX = {VW{1'b1}};

    localparam int N_RANDOM = 240;
    // The receiver holds off for this long once, so that an emit backs up and the
    // block stops taking commands.
    localparam int HOLD_CYCLES = 300;
    // Long enough to drain any beat that could still be in flight after an emit.
    localparam int DRAIN_CYCLES = 2 * CAP + 16;
    // No acceptance on either channel for this long means the block is stuck.
    // The longest legal silence is the forced receiver hold plus a random stall.
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [VW-1:0] value_res;
        logic          valid_res;
        logic          last;
        logic          list_kind;
        logic          overflow;
    } set_beat_t;

    // Keeps a private copy of both sets and the sticky overflow flag, turns every
    // accepted command into the output beats it must cause, and checks the
    // beats coming out of the block against them in order.
    class set_scoreboard;
        logic [VW-1:0] set_a[$];
        logic [VW-1:0] set_b[$];
        logic          dropped_flag;
        set_beat_t     expected[$];
        int            fail_count;

        function new();
            dropped_flag = 1'b0;
            fail_count   = 0;
        endfunction

        function void add_member(bit to_b, logic [VW-1:0] v);
            logic [VW-1:0] s[$];
            int pos;
            if (to_b)
                s = set_b;
            else
                s = set_a;
            pos = 0;
            while (pos < s.size() && s[pos] < v)
                pos++;
            if (pos < s.size() && s[pos] == v)
                return;
            if (s.size() >= CAP)
            begin
                dropped_flag = 1'b1;
                return;
            end
            s.insert(pos, v);
            if (to_b)
                set_b = s;
            else
                set_a = s;
        endfunction

        // Walks both sorted sets in step, the same way a merge would.
        function void emit_list(bit want_union);
            logic [VW-1:0] members[$];
            set_beat_t beat;
            int i;
            int j;
            i = 0;
            j = 0;
            while (i < set_a.size() || j < set_b.size())
            begin
                if (i < set_a.size() && j < set_b.size() && set_a[i] == set_b[j])
                begin
                    members.push_back(set_a[i]);
                    i++;
                    j++;
                end
                else if (j >= set_b.size() || (i < set_a.size() && set_a[i] < set_b[j]))
                begin
                    if (want_union)
                        members.push_back(set_a[i]);
                    i++;
                end
                else
                begin
                    if (want_union)
                        members.push_back(set_b[j]);
                    j++;
                end
            end
            beat.list_kind = want_union ? ssiu_pkg::LIST_UNION : ssiu_pkg::LIST_INTERSECT;
            beat.overflow  = dropped_flag;
            if (members.size() == 0)
            begin
                // Nothing found: a single beat with valid_res low closes the run.
                beat.value_res = '0;
                beat.valid_res = 1'b0;
                beat.last      = 1'b1;
                expected.push_back(beat);
            end
            else
            begin
                for (int k = 0; k < members.size(); k++)
                begin
                    beat.value_res = members[k];
                    beat.valid_res = 1'b1;
                    beat.last      = (k == members.size() - 1);
                    expected.push_back(beat);
                end
            end
        endfunction

        function void note_command(logic [ssiu_pkg::CMD_W-1:0] cmd, logic [VW-1:0] v);
            case (cmd)
                ssiu_pkg::CMD_INSERT_A: add_member(1'b0, v);
                ssiu_pkg::CMD_INSERT_B: add_member(1'b1, v);
                ssiu_pkg::CMD_EMIT_AND: emit_list(1'b0);
                ssiu_pkg::CMD_EMIT_OR:  emit_list(1'b1);
                ssiu_pkg::CMD_CLEAR:
                begin
                    // The overflow flag is sticky and survives a clear.
                    set_a.delete();
                    set_b.delete();
                end
                default: ;
            endcase
        endfunction

        function void check_beat(set_beat_t got);
            set_beat_t want;
            if (expected.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected beat: value=%h valid=%b last=%b kind=%b ovf=%b",
                             got.value_res, got.valid_res, got.last, got.list_kind,
                             got.overflow);
                return;
            end
            want = expected.pop_front();
            if (got.value_res !== want.value_res || got.valid_res !== want.valid_res ||
                got.last !== want.last || got.list_kind !== want.list_kind ||
                got.overflow !== want.overflow)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("mismatch: expected value=%h valid=%b last=%b kind=%b ovf=%b",
                             want.value_res, want.valid_res, want.last, want.list_kind,
                             want.overflow);
                    $display("          actual   value=%h valid=%b last=%b kind=%b ovf=%b",
                             got.value_res, got.valid_res, got.last, got.list_kind,
                             got.overflow);
                end
            end
        endfunction

        function int outstanding();
            return expected.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [ssiu_pkg::CMD_W-1:0] command = ssiu_pkg::CMD_CLEAR;
    logic [VW-1:0]              value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [VW-1:0]              value_res;
    logic                       valid_res;
    logic                       last;
    logic                       list_kind;
    logic                       overflow;

    set_scoreboard sb = new();

    // Idle rates in percent, set by the stimulus process for each phase.
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    // The stimulus process bumps hold_requests; the receiver answers each one
    // with a long stretch of out_ready low and counts it in holds_done.
    int hold_requests = 0;
    int holds_done = 0;
    // Commands the block acts on; the unused codes are not counted.
    int items_sent = 0;
    int quiet_cycles = 0;

    sorted_set_intersect_union #(
        .CAPACITY    (CAP),
        .VALUE_WIDTH (VW)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value_res (value_res),
        .valid_res (valid_res),
        .last      (last),
        .list_kind (list_kind),
        .overflow  (overflow)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offers one command beat and returns at the edge where it is taken. A random
    // gap may come first. in_valid stays high into the next call when no gap is
    // drawn, so back-to-back beats follow each other with no gap.
    task automatic send_beat(input logic [ssiu_pkg::CMD_W-1:0] cmd,
                             input logic [VW-1:0] val);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_command(cmd, val);
        if (cmd <= ssiu_pkg::CMD_CLEAR)
            items_sent++;
    endtask

    // Receiver: draws out_ready every cycle, or holds it low while a requested
    // hold is running, and hands every accepted beat to the scoreboard.
    initial
    begin
        set_beat_t got;
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= dst_idle_pct);
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.value_res = value_res;
                got.valid_res = valid_res;
                got.last      = last;
                got.list_kind = list_kind;
                got.overflow  = overflow;
                sb.check_beat(got);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [VW-1:0] pool[$];
        logic [VW-1:0] filled[$];
        logic [VW-1:0] base;
        logic [VW-1:0] v;
        int random_start;
        int phase;
        int mode;
        int pool_n;
        int na;
        int nb;
        int seq_no;
        bit pressure_done;

        pressure_done = 1'b0;
        seq_no = 0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with the first idle mix.
        src_idle_pct = 22;
        dst_idle_pct = 69;
        // Emits on two empty sets give the empty-list beat of each kind.
        send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
        send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
        // Extremes of the value range, with repeats that must change nothing.
        send_beat(ssiu_pkg::CMD_INSERT_A, '0);
        send_beat(ssiu_pkg::CMD_INSERT_A, VAL_MAX);
        send_beat(ssiu_pkg::CMD_INSERT_A, VAL_MAX);
        send_beat(ssiu_pkg::CMD_INSERT_B, VAL_MAX);
        send_beat(ssiu_pkg::CMD_INSERT_B, 24'h000005);
        send_beat(ssiu_pkg::CMD_INSERT_B, 24'h000005);
        send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
        send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
        // Unused codes carry arbitrary values and must leave the sets alone.
        send_beat(CMD_RSVD_0, 24'hAAAAAA);
        send_beat(CMD_RSVD_1, 24'h555555);
        send_beat(CMD_RSVD_2, VAL_MAX);
        // Values on either side of the top bit, so the compare sees a carry.
        send_beat(ssiu_pkg::CMD_INSERT_A, 24'h800000);
        send_beat(ssiu_pkg::CMD_INSERT_B, 24'h7FFFFF);
        send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
        send_beat(ssiu_pkg::CMD_CLEAR, VW'($urandom));
        send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
        // One set empty and the other not: no intersection, a one-member union.
        send_beat(ssiu_pkg::CMD_INSERT_B, 24'h123456);
        send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
        send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
        send_beat(ssiu_pkg::CMD_CLEAR, VW'($urandom));

        // Random part. Most of it is well-formed: usually clear, load both sets from a
        // shared pool of nearby values so that they overlap and repeat, then emit.
        // The first sequence always fills A to capacity, often more, so the sticky
        // overflow flag shows up early; the rest is noise from any command code.
        random_start = items_sent;
        while (items_sent < random_start + N_RANDOM)
        begin
            phase = (items_sent - random_start) * 3 / N_RANDOM;
            case (phase)
                0:
                begin
                    src_idle_pct = 22;
                    dst_idle_pct = 69;
                end
                1:
                begin
                    src_idle_pct = 69;
                    dst_idle_pct = 22;
                end
                default:
                begin
                    src_idle_pct = 0;
                    dst_idle_pct = 0;
                end
            endcase

            if (phase >= 2 && !pressure_done)
            begin
                // Stall the receiver and keep offering commands: the emit
                // backs up and the block has to hold its input off.
                pressure_done = 1'b1;
                hold_requests++;
                send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
                send_beat(ssiu_pkg::CMD_INSERT_A, VW'($urandom));
                send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
            end

            mode = (seq_no == 0) ? 0 : $urandom_range(0, 9);
            seq_no++;
            case (mode)
                0:
                begin
                    // Fill A to its capacity or past it, then load B partly from A.
                    filled.delete();
                    send_beat(ssiu_pkg::CMD_CLEAR, VW'($urandom));
                    na = CAP + $urandom_range(0, 3);
                    for (int k = 0; k < na; k++)
                    begin
                        v = VW'($urandom);
                        filled.push_back(v);
                        send_beat(ssiu_pkg::CMD_INSERT_A, v);
                    end
                    // A member that is already there must not count as a drop.
                    send_beat(ssiu_pkg::CMD_INSERT_A, filled[$urandom_range(0, CAP - 1)]);
                    nb = $urandom_range(0, CAP + 3);
                    for (int k = 0; k < nb; k++)
                    begin
                        if ($urandom_range(1))
                            v = filled[$urandom_range(0, filled.size() - 1)];
                        else
                            v = VW'($urandom);
                        send_beat(ssiu_pkg::CMD_INSERT_B, v);
                    end
                    send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
                    send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
                end
                8, 9:
                begin
                    for (int k = $urandom_range(1, 6); k > 0; k--)
                        send_beat(ssiu_pkg::CMD_W'($urandom_range(0, 7)), VW'($urandom));
                end
                default:
                begin
                    pool.delete();
                    base = VW'($urandom);
                    pool_n = $urandom_range(1, 10);
                    for (int k = 0; k < pool_n; k++)
                        pool.push_back(base + VW'($urandom_range(0, 40)));
                    if ($urandom_range(3) == 0)
                        pool.push_back('0);
                    if ($urandom_range(3) == 0)
                        pool.push_back(VAL_MAX);
                    if ($urandom_range(99) < 70)
                        send_beat(ssiu_pkg::CMD_CLEAR, VW'($urandom));
                    na = $urandom_range(0, 8);
                    nb = $urandom_range(0, 8);
                    // Interleave the loads of A and B at random.
                    while (na + nb > 0)
                    begin
                        v = pool[$urandom_range(0, pool.size() - 1)];
                        if (nb == 0 || (na > 0 && $urandom_range(1)))
                        begin
                            send_beat(ssiu_pkg::CMD_INSERT_A, v);
                            na--;
                        end
                        else
                        begin
                            send_beat(ssiu_pkg::CMD_INSERT_B, v);
                            nb--;
                        end
                    end
                    case ($urandom_range(0, 3))
                        0: send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
                        1: send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
                        2:
                        begin
                            send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
                            send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
                        end
                        default:
                        begin
                            send_beat(ssiu_pkg::CMD_EMIT_OR, VW'($urandom));
                            send_beat(ssiu_pkg::CMD_EMIT_AND, VW'($urandom));
                        end
                    endcase
                end
            endcase
        end

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        // Give a stray beat time to show up before judging the run.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sorted_set_intersect_union.f */
src/ssiu_pkg.sv
src/ssiu_cell.sv
src/ssiu_chain.sv
src/sorted_set_intersect_union.sv
dv/tb_sorted_set_intersect_union.sv
